@@ rtl/mcfd_pkg.sv @@
// Package for the magic/length/CRC-32 frame deframer.
// Holds frame constants, the engine state type, the channel beat types and the CRC step.
// Used by every module of the deframer.
package mcfd_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int HDR_LEN     = 13;
   localparam int CRC_LEN     = 4;
   localparam int BUF_LEN     = HDR_LEN + MAX_PAYLOAD + CRC_LEN;
   localparam int MEM_DEPTH   = 64;
   localparam int PTR_W       = 6;

   // Magic 'M','B','G','W', first byte in the low lane.
   localparam logic [31:0] MAGIC_WORD = 32'h5747424D;
   localparam logic [7:0]  MAGIC_LEAD = 8'h4D;

   // Header byte offsets.
   localparam logic [PTR_W-1:0] OFS_TYPE    = 6'd4;
   localparam logic [PTR_W-1:0] OFS_TID_LO  = 6'd5;
   localparam logic [PTR_W-1:0] OFS_TID_HI  = 6'd8;
   localparam logic [PTR_W-1:0] OFS_LEN_HI  = 6'd12;
   localparam logic [PTR_W-1:0] OFS_PAYLOAD = 6'd13;
   localparam logic [PTR_W-1:0] FRAME_OVH   = 6'd17;
   localparam logic [PTR_W-1:0] LAST_CRC    = 6'd16;
   localparam logic [PTR_W-1:0] BUF_FULL    = 6'd49;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_HDR  = 5'b00100,
      ST_CRC  = 5'b01000,
      ST_EMIT = 5'b10000
   } eng_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } byte_beat_type;

   typedef struct packed {
      logic [7:0]  frame_type;
      logic [31:0] txn_id;
      logic [5:0]  pay_len;
      logic        has_payload;
      logic [7:0]  payload_byte;
      logic        last_of_frame;
   } rsp_item_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/mcfd_if.sv @@
// Channel interfaces of the deframer: received byte channel and frame result channel.
// Depends on nothing.
interface mcfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mcfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_type;
   logic [31:0] txn_id;
   logic [5:0]  pay_len;
   logic        has_payload;
   logic [7:0]  payload_byte;
   logic        last_of_frame;
   modport source (output valid, output frame_type, output txn_id,
                   output pay_len, output has_payload, output payload_byte,
                   output last_of_frame, input ready);
   modport sink   (input valid, input frame_type, input txn_id,
                   input pay_len, input has_payload, input payload_byte,
                   input last_of_frame, output ready);
endinterface

@@ rtl/mcfd_front.sv @@
// Front end: two-entry byte queue between the receive channel and the engine.
// Depends on mcfd_pkg and mcfd_if.
module mcfd_front (
   input  logic                   clock,
   input  logic                   reset,
   mcfd_req_if.sink               req_chan,
   output mcfd_pkg::byte_beat_type eng_beat,
   input  logic                   eng_ready
);

   logic [7:0] slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_chan.ready   = (count_ff != 2'd2);
   assign push             = req_chan.valid && req_chan.ready;
   assign eng_beat.valid   = (count_ff != 2'd0);
   assign eng_beat.rx_byte = slot_ff[rd_ptr_ff];
   assign pop              = eng_beat.valid && eng_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_chan.rx_byte;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/mcfd_engine.sv @@
// Back end: window memory, magic scan, header parse, CRC check and payload emit.
// Depends on mcfd_pkg.
module mcfd_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  mcfd_pkg::byte_beat_type in_beat,
   output logic                    in_ready,
   output logic                    out_valid,
   output mcfd_pkg::rsp_item_type  out_item,
   input  logic                    out_ready
);

   localparam int PW = mcfd_pkg::PTR_W;

   logic [7:0] mem [mcfd_pkg::MEM_DEPTH];
   logic [7:0] rd_data_ff;

   mcfd_pkg::eng_state_type state_ff, state_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] fill_ff, fill_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic          wait_ff, wait_in;
   logic [1:0]    match_ff, match_in;
   logic [7:0]    type_ff, type_in;
   logic [31:0]   tid_ff, tid_in;
   logic [31:0]   plen_ff, plen_in;
   logic [31:0]   crc_ff, crc_in;
   logic [31:0]   crc_rx_ff, crc_rx_in;
   logic          out_valid_ff, out_valid_in;
   mcfd_pkg::rsp_item_type item_ff, item_in;

   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [PW-1:0] rd_addr;
   logic [PW-1:0] plen6;
   logic [PW-1:0] total;
   logic          out_free;
   logic [31:0]   plen_next;
   logic [31:0]   crc_rx_next;
   logic [PW-1:0] pos;

   assign rd_addr   = head_ff + idx_ff;
   assign plen6     = plen_ff[PW-1:0];
   assign total     = mcfd_pkg::FRAME_OVH + plen6;
   assign out_free  = !out_valid_ff || out_ready;
   assign in_ready  = (state_ff == mcfd_pkg::ST_IDLE);
   assign out_valid = out_valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      wait_in      = wait_ff;
      match_in     = match_ff;
      type_in      = type_ff;
      tid_in       = tid_ff;
      plen_in      = plen_ff;
      crc_in       = crc_ff;
      crc_rx_in    = crc_rx_ff;
      out_valid_in = out_valid_ff && !out_ready;
      item_in      = item_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff + fill_ff;
      plen_next    = {rd_data_ff, plen_ff[31:8]};
      crc_rx_next  = {rd_data_ff, crc_rx_ff[31:8]};
      pos          = idx_ff - 6'd3;

      case (state_ff)
         mcfd_pkg::ST_IDLE: begin
            if (in_beat.valid) begin
               wr_en = 1'b1;
               if (fill_ff >= mcfd_pkg::BUF_FULL) begin
                  wr_addr = head_ff;
                  fill_in = 6'd1;
               end else begin
                  fill_in = fill_ff + 6'd1;
               end
               state_in = mcfd_pkg::ST_SCAN;
               idx_in   = '0;
               match_in = '0;
               wait_in  = 1'b0;
            end
         end
         mcfd_pkg::ST_SCAN: begin
            if (!wait_ff) begin
               if (idx_ff == fill_ff) begin
                  // no magic: keep the trailing partial magic only
                  head_in  = head_ff + fill_ff - {4'd0, match_ff};
                  fill_in  = {4'd0, match_ff};
                  state_in = mcfd_pkg::ST_IDLE;
               end else begin
                  wait_in = 1'b1;
               end
            end else begin
               wait_in = 1'b0;
               idx_in  = idx_ff + 6'd1;
               if (rd_data_ff == mcfd_pkg::MAGIC_WORD[match_ff*8 +: 8]) begin
                  if (match_ff == 2'd3) begin
                     head_in = head_ff + pos;
                     fill_in = fill_ff - pos;
                     if ((fill_ff - pos) < 6'(mcfd_pkg::HDR_LEN)) begin
                        state_in = mcfd_pkg::ST_IDLE;
                     end else begin
                        state_in = mcfd_pkg::ST_HDR;
                        idx_in   = mcfd_pkg::OFS_TYPE;
                     end
                  end else begin
                     match_in = match_ff + 2'd1;
                  end
               end else begin
                  match_in = (rd_data_ff == mcfd_pkg::MAGIC_LEAD) ? 2'd1 : 2'd0;
               end
            end
         end
         mcfd_pkg::ST_HDR: begin
            if (!wait_ff) begin
               wait_in = 1'b1;
            end else begin
               wait_in = 1'b0;
               idx_in  = idx_ff + 6'd1;
               if (idx_ff == mcfd_pkg::OFS_TYPE) begin
                  type_in = rd_data_ff;
               end else if (idx_ff >= mcfd_pkg::OFS_TID_LO && idx_ff <= mcfd_pkg::OFS_TID_HI) begin
                  tid_in = {rd_data_ff, tid_ff[31:8]};
               end else begin
                  plen_in = plen_next;
               end
               if (idx_ff == mcfd_pkg::OFS_LEN_HI) begin
                  if (plen_next > 32'(mcfd_pkg::MAX_PAYLOAD)) begin
                     // oversize length: drop one byte and rescan
                     head_in  = head_ff + 6'd1;
                     fill_in  = fill_ff - 6'd1;
                     state_in = mcfd_pkg::ST_SCAN;
                     idx_in   = '0;
                     match_in = '0;
                  end else if (fill_ff < (mcfd_pkg::FRAME_OVH + plen_next[PW-1:0])) begin
                     state_in = mcfd_pkg::ST_IDLE;
                  end else begin
                     state_in = mcfd_pkg::ST_CRC;
                     idx_in   = '0;
                     crc_in   = mcfd_pkg::CRC_INIT;
                  end
               end
            end
         end
         mcfd_pkg::ST_CRC: begin
            if (!wait_ff) begin
               wait_in = 1'b1;
            end else begin
               wait_in = 1'b0;
               idx_in  = idx_ff + 6'd1;
               if (idx_ff < (mcfd_pkg::OFS_PAYLOAD + plen6)) begin
                  crc_in = mcfd_pkg::crc_byte(crc_ff, rd_data_ff);
               end else begin
                  crc_rx_in = crc_rx_next;
               end
               if (idx_ff == (mcfd_pkg::LAST_CRC + plen6)) begin
                  if ((crc_ff ^ mcfd_pkg::CRC_INIT) == crc_rx_next) begin
                     state_in = mcfd_pkg::ST_EMIT;
                     idx_in   = mcfd_pkg::OFS_PAYLOAD;
                  end else begin
                     head_in  = head_ff + 6'd1;
                     fill_in  = fill_ff - 6'd1;
                     state_in = mcfd_pkg::ST_SCAN;
                     idx_in   = '0;
                     match_in = '0;
                  end
               end
            end
         end
         mcfd_pkg::ST_EMIT: begin
            if (!wait_ff) begin
               wait_in = 1'b1;
            end else if (out_free) begin
               out_valid_in          = 1'b1;
               item_in.frame_type    = type_ff;
               item_in.txn_id        = tid_ff;
               item_in.pay_len       = plen6;
               wait_in               = 1'b0;
               idx_in                = idx_ff + 6'd1;
               if (plen6 == '0) begin
                  item_in.has_payload   = 1'b0;
                  item_in.payload_byte  = '0;
                  item_in.last_of_frame = 1'b1;
               end else begin
                  item_in.has_payload   = 1'b1;
                  item_in.payload_byte  = rd_data_ff;
                  item_in.last_of_frame = (idx_ff == (mcfd_pkg::OFS_LEN_HI + plen6));
               end
               if (item_in.last_of_frame) begin
                  head_in  = head_ff + total;
                  fill_in  = fill_ff - total;
                  idx_in   = '0;
                  match_in = '0;
                  state_in = ((fill_ff - total) == '0) ? mcfd_pkg::ST_IDLE : mcfd_pkg::ST_SCAN;
               end
            end
         end
         default: begin
            state_in = mcfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= in_beat.rx_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      match_ff  <= match_in;
      type_ff   <= type_in;
      tid_ff    <= tid_in;
      plen_ff   <= plen_in;
      crc_ff    <= crc_in;
      crc_rx_ff <= crc_rx_in;
      item_ff   <= item_in;
      if (reset) begin
         state_ff     <= mcfd_pkg::ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         wait_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         wait_ff      <= wait_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

@@ rtl/magic_crc_frame_deframer.sv @@
// Top level of the magic/length/CRC-32 frame deframer.
// Depends on mcfd_pkg, mcfd_if, mcfd_front and mcfd_engine.
//
// Usage:
//   req_chan carries one received byte per beat (valid/ready). rsp_chan carries
//   one result beat per payload byte of each good frame: type, transaction id,
//   length, the byte and a last mark. An empty good frame gives one beat with
//   has_payload low and last_of_frame high.
// Flow:
//   A two-entry queue takes bytes while the engine works. The engine handles one
//   byte at a time; it reads the 64-entry window memory through a registered read.
//   Each accepted byte is written to the window and followed by a magic scan.
//   A complete frame adds a header parse, a CRC pass and one read per emitted
//   beat; a failed CRC or length rescans from the next byte, so the worst case
//   is several such passes per byte.
// Reset:
//   Synchronous, active high. Empties the queue, the window and the result
//   register; window memory contents are not cleared.
// Stall:
//   A result beat holds in the output register while rsp_chan.ready is low;
//   the engine pauses and the queue fills, then req_chan.ready drops.
module magic_crc_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   mcfd_req_if.sink   req_chan,
   mcfd_rsp_if.source rsp_chan
);

   mcfd_pkg::byte_beat_type eng_beat;
   logic                    eng_ready;
   mcfd_pkg::rsp_item_type  item;
   logic                    item_valid;

   mcfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .eng_beat  (eng_beat),
      .eng_ready (eng_ready)
   );

   mcfd_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (eng_beat),
      .in_ready  (eng_ready),
      .out_valid (item_valid),
      .out_item  (item),
      .out_ready (rsp_chan.ready)
   );

   // drive the result channel from the engine's output register
   assign rsp_chan.valid         = item_valid;
   assign rsp_chan.frame_type    = item.frame_type;
   assign rsp_chan.txn_id        = item.txn_id;
   assign rsp_chan.pay_len       = item.pay_len;
   assign rsp_chan.has_payload   = item.has_payload;
   assign rsp_chan.payload_byte  = item.payload_byte;
   assign rsp_chan.last_of_frame = item.last_of_frame;

endmodule

@@ sim/magic_crc_frame_deframer_tb.sv @@
// Self-checking bench for the magic/length/CRC-32 frame deframer.
// Depends on mcfd_pkg, mcfd_if and magic_crc_frame_deframer.
module magic_crc_frame_deframer_tb;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES   = 2000;

   // Frame model and store of expected result beats.
   class frame_scoreboard;
      logic [7:0]             win [0:mcfd_pkg::BUF_LEN-1];
      int                     fill;
      mcfd_pkg::rsp_item_type pending_beats [$];
      int                     mismatches;

      function new();
         fill = 0;
         mismatches = 0;
      endfunction

      function logic [31:0] le32(int at);
         return {win[at+3], win[at+2], win[at+1], win[at]};
      endfunction

      function void drop(int n);
         if (n >= fill) begin
            fill = 0;
         end else begin
            for (int i = 0; i < fill - n; i++) win[i] = win[i+n];
            fill = fill - n;
         end
      endfunction

      function bit magic_match(int pos, int len);
         for (int k = 0; k < len; k++)
            if (win[pos+k] != mcfd_pkg::MAGIC_WORD[8*k +: 8]) return 0;
         return 1;
      endfunction

      function logic [31:0] frame_crc(int len);
         logic [31:0] c;
         c = 32'hFFFFFFFF;
         for (int i = 0; i < len; i++) begin
            c = c ^ {24'd0, win[i]};
            for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
         end
         return ~c;
      endfunction

      // Append one received byte and rescan; push the beats it releases, at most MAX_PAYLOAD per byte.
      function void note_byte(logic [7:0] rx);
         int pos, keep, count;
         logic [31:0] plen;
         mcfd_pkg::rsp_item_type it;
         count = 0;
         if (fill >= mcfd_pkg::BUF_LEN) fill = 0;
         win[fill] = rx;
         fill++;
         forever begin
            pos = fill;
            for (int i = 0; i + 4 <= fill; i++)
               if (magic_match(i, 4)) begin
                  pos = i;
                  break;
               end
            if (pos == fill) begin
               keep = (fill < 3) ? fill : 3;
               while (keep != 0 && !magic_match(fill - keep, keep)) keep--;
               for (int i = 0; i < keep; i++) win[i] = win[fill-keep+i];
               fill = keep;
               return;
            end
            if (pos != 0) drop(pos);
            if (fill < mcfd_pkg::HDR_LEN) return;
            plen = le32(9);
            if (plen > mcfd_pkg::MAX_PAYLOAD) begin
               drop(1);
               continue;
            end
            if (fill < mcfd_pkg::HDR_LEN + plen + mcfd_pkg::CRC_LEN) return;
            if (frame_crc(mcfd_pkg::HDR_LEN + plen) == le32(mcfd_pkg::HDR_LEN + plen)) begin
               it.frame_type = win[4];
               it.txn_id = le32(5);
               it.pay_len = plen[5:0];
               if (plen == 0) begin
                  it.has_payload = 0;
                  it.payload_byte = 0;
                  it.last_of_frame = 1;
                  if (count < mcfd_pkg::MAX_PAYLOAD) begin
                     pending_beats.push_back(it);
                     count++;
                  end
               end else begin
                  for (int i = 0; i < plen && count < mcfd_pkg::MAX_PAYLOAD; i++) begin
                     it.has_payload = 1;
                     it.payload_byte = win[mcfd_pkg::HDR_LEN+i];
                     it.last_of_frame = (i + 1 == plen);
                     pending_beats.push_back(it);
                     count++;
                  end
               end
               drop(mcfd_pkg::HDR_LEN + plen + mcfd_pkg::CRC_LEN);
            end else begin
               drop(1);
            end
            if (fill == 0) return;
         end
      endfunction

      function void check_beat(mcfd_pkg::rsp_item_type got);
         mcfd_pkg::rsp_item_type want;
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
         end
         want = pending_beats.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat mismatch: expected %h, got %h", want, got);
         end
      endfunction
   endclass

   logic clock, reset;
   mcfd_req_if req_chan ();
   mcfd_rsp_if rsp_chan ();

   magic_crc_frame_deframer dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   frame_scoreboard sb;
   int idle_cycles;
   int stall_mode;
   bit done;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial sb = new();

   // Sample both channels at the rising edge; feed the model and check results.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_byte(req_chan.rx_byte);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_beat({rsp_chan.frame_type, rsp_chan.txn_id,
                           rsp_chan.pay_len, rsp_chan.has_payload,
                           rsp_chan.payload_byte, rsp_chan.last_of_frame});
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver stall pattern: ready phases switch between always-on, sparse and bursty.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Hold one byte on the channel until it is accepted.
   task automatic send_byte(input logic [7:0] b);
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Sender burst/gap shaping between beats.
   int burst_left;
   task automatic send_paced(input logic [7:0] b);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      send_byte(b);
      burst_left--;
   endtask

   // Build a frame: magic, type, id, length, payload, CRC; optionally corrupt it.
   task automatic send_frame(input logic [7:0] ftype, input logic [31:0] tid,
                             input logic [31:0] plen, input int pay_n, input bit bad_crc);
      logic [7:0] bytes [$];
      logic [31:0] c;
      for (int k = 0; k < 4; k++) bytes.push_back(mcfd_pkg::MAGIC_WORD[8*k +: 8]);
      bytes.push_back(ftype);
      for (int k = 0; k < 4; k++) bytes.push_back(tid[8*k +: 8]);
      for (int k = 0; k < 4; k++) bytes.push_back(plen[8*k +: 8]);
      for (int k = 0; k < pay_n; k++) bytes.push_back(8'($urandom));
      c = 32'hFFFFFFFF;
      foreach (bytes[i]) begin
         c = c ^ {24'd0, bytes[i]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ mcfd_pkg::CRC_POLY) : (c >> 1);
      end
      c = ~c;
      if (bad_crc) c = c ^ (32'h1 << $urandom_range(0, 31));
      for (int k = 0; k < 4; k++) bytes.push_back(c[8*k +: 8]);
      foreach (bytes[i]) send_paced(bytes[i]);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending_beats.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready = 1'b0;
      idle_cycles = 0;
      stall_mode = 0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, empty frame, max payload, oversize length, bad CRC,
      // partial magic carried over, frame hidden inside a failed outer frame.
      send_frame(8'h00, 32'h0000_0000, 0, 0, 0);
      send_frame(8'hFF, 32'hFFFF_FFFF, 32, 32, 0);
      send_frame(8'hA5, 32'h1234_5678, 32'hFFFF_FFFF, 0, 0);
      send_frame(8'h5A, 32'h8000_0001, 33, 2, 0);
      send_frame(8'h11, 32'hCAFE_0001, 3, 3, 1);
      send_byte(8'h4D); send_byte(8'h42); send_byte(8'h47);
      send_frame(8'h22, 32'h0000_00FF, 1, 1, 0);
      // Outer header claims 20 bytes; an inner good frame sits in its payload.
      send_frame(8'h33, 32'h0BAD_0BAD, 20, 0, 0);
      send_frame(8'h44, 32'h00C0_FFEE, 2, 2, 0);
      send_frame(8'h55, 32'h7, 0, 0, 0);
      wait_drained();

      // Random: mostly well-formed frames with small payloads, plus noise and
      // broken frames.
      n = 0;
      while (n < 40) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               send_paced(($urandom_range(0, 3) == 0) ? mcfd_pkg::MAGIC_LEAD : 8'($urandom));
               n++;
            end
            2: begin
               send_frame(8'($urandom), $urandom, $urandom_range(0, 8), 0, 0);
               n += 17;
            end
            3: begin
               send_frame(8'($urandom), $urandom, $urandom_range(0, 6), 0, 1);
               n += 17;
            end
            default: begin
               int pl;
               pl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32)
                                                 : $urandom_range(0, 5);
               send_frame(8'($urandom), $urandom, pl, pl, 0);
               n += 17 + pl;
            end
         endcase
         if (n > 16 && n < 40) wait_drained();
      end

      req_chan.valid <= 1'b0;
      while (sb.pending_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_beats.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
